// ===== hdl/pipt_pkg.sv =====
// ----------------------------------------------------------------------------
// pipt_pkg
// Shared types and constants of the point-in-prism tester: request and
// result payloads, register codes, datapath widths and control structs.
// ----------------------------------------------------------------------------
package pipt_pkg;

    // Vertex table size and derived index widths
    localparam int MAX_VERTICES = 16;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    // Field widths fixed by the interface
    localparam int COORD_W   = 32;
    localparam int VIDX_W    = 4;
    localparam int VCNT_W    = 5;
    localparam int HH_W      = 30;
    localparam int CFG_IDX_W = 3;

    // Datapath widths: absolute vertex, edge differences, split multiplier
    localparam int ABS_W  = COORD_W + 1;
    localparam int DIFF_W = ABS_W + 1;
    localparam int PART_W = DIFF_W / 2;
    localparam int MPL_W  = PART_W + 1;
    localparam int PROD_W = DIFF_W + MPL_W;
    localparam int ACC_W  = 2 * DIFF_W + 1;
    localparam int BAND_W = COORD_W + 2;

    // Request kinds
    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_TEST = 1'b1
    } req_kind_t;

    // Configuration register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VERTEX_COUNT = 3'd0,
        REG_CENTER_X     = 3'd1,
        REG_CENTER_Y     = 3'd2,
        REG_CENTER_Z     = 3'd3,
        REG_HALF_HEIGHT  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        req_kind_t                   req_type;
        logic [VIDX_W-1:0]           vertex_index;
        logic signed [COORD_W-1:0]   pos_x;
        logic signed [COORD_W-1:0]   pos_y;
        logic signed [COORD_W-1:0]   pos_z;
    } req_t;

    typedef struct packed {
        logic inside_res;
        logic in_polygon;
        logic in_band;
    } res_t;

    // One vertex table word: offsets relative to the center
    typedef struct packed {
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
    } vert_t;

    // Command to the shared multiply-accumulate unit
    typedef struct packed {
        logic issue;
        logic clear;
        logic shift;
        logic sub;
    } mac_op_t;

    // Sequencer status toward the top level
    typedef struct packed {
        logic idle;
        logic done;
        logic poly;
    } seq_stat_t;

endpackage

// ===== hdl/pipt_ram.sv =====
// ----------------------------------------------------------------------------
// pipt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pipt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/pipt_mac.sv =====
// ----------------------------------------------------------------------------
// pipt_mac
// Shared multiply-accumulate unit: one signed partial product per cycle,
// registered, then added to, subtracted from or loaded into a wide accumulator.
// ----------------------------------------------------------------------------
module pipt_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pipt_pkg::mac_op_t                    op,
    input  logic signed [pipt_pkg::DIFF_W-1:0]   mcand,
    input  logic signed [pipt_pkg::MPL_W-1:0]    mplier,
    output logic signed [pipt_pkg::ACC_W-1:0]    acc
);

    logic signed [pipt_pkg::PROD_W-1:0] prod_reg;
    logic signed [pipt_pkg::PROD_W-1:0] prod_next;
    pipt_pkg::mac_op_t                  op_reg;
    logic signed [pipt_pkg::ACC_W-1:0]  acc_reg;
    logic signed [pipt_pkg::ACC_W-1:0]  acc_next;
    logic signed [pipt_pkg::ACC_W-1:0]  term;

    // Form the partial product
    assign prod_next = mcand * mplier;

    // Align the registered product and fold it into the accumulator
    always_comb
    begin
        term = pipt_pkg::ACC_W'(prod_reg);
        if (op_reg.shift)
        begin
            term = term <<< pipt_pkg::PART_W;
        end
        acc_next = acc_reg;
        if (op_reg.issue)
        begin
            priority if (op_reg.clear)
            begin
                acc_next = op_reg.sub ? -term : term;
            end
            else if (op_reg.sub)
            begin
                acc_next = acc_reg - term;
            end
            else
            begin
                acc_next = acc_reg + term;
            end
        end
    end

    // Hold the command stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= '0;
        end
        else
        begin
            op_reg <= op;
        end
    end

    // Product and accumulator
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ===== hdl/pipt_ctrl.sv =====
// ----------------------------------------------------------------------------
// pipt_ctrl
// Edge-walk sequencer: reads one vertex per step, checks whether the edge
// spans the point's row and, if so, runs the sign-corrected cross-multiply
// through the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
module pipt_ctrl (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [pipt_pkg::COORD_W-1:0]    point_x,
    input  logic signed [pipt_pkg::COORD_W-1:0]    point_y,
    input  logic [pipt_pkg::VCNT_W-1:0]            vertex_count,
    input  logic signed [pipt_pkg::COORD_W-1:0]    center_x,
    input  logic signed [pipt_pkg::COORD_W-1:0]    center_y,
    input  logic                                   res_free,
    output logic [pipt_pkg::ADDR_W-1:0]            rd_addr,
    input  pipt_pkg::vert_t                        rd_data,
    output pipt_pkg::seq_stat_t                    stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD,
        S_CLOSE,
        S_EDGE,
        S_MUL,
        S_WAIT,
        S_DECIDE,
        S_FINISH
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [pipt_pkg::CNT_W-1:0]     idx_reg;
    logic [pipt_pkg::CNT_W-1:0]     idx_next;
    logic [pipt_pkg::CNT_W-1:0]     n_reg;
    logic [pipt_pkg::CNT_W-1:0]     n_next;
    logic [pipt_pkg::CNT_W-1:0]     n_eff;
    logic [1:0]                     step_reg;
    logic [1:0]                     step_next;
    logic                           poly_reg;
    logic                           poly_next;
    logic                           closing_reg;
    logic                           closing_next;

    logic signed [pipt_pkg::COORD_W-1:0] tx_reg;
    logic signed [pipt_pkg::COORD_W-1:0] ty_reg;
    logic signed [pipt_pkg::ABS_W-1:0]   prev_x_reg;
    logic signed [pipt_pkg::ABS_W-1:0]   prev_y_reg;
    logic signed [pipt_pkg::ABS_W-1:0]   cur_x_reg;
    logic signed [pipt_pkg::ABS_W-1:0]   cur_y_reg;
    logic signed [pipt_pkg::ABS_W-1:0]   first_x_reg;
    logic signed [pipt_pkg::ABS_W-1:0]   first_y_reg;
    logic signed [pipt_pkg::DIFF_W-1:0]  a_reg;
    logic signed [pipt_pkg::DIFF_W-1:0]  b_reg;
    logic signed [pipt_pkg::DIFF_W-1:0]  c_reg;
    logic signed [pipt_pkg::DIFF_W-1:0]  d_reg;
    logic                                dypos_reg;

    logic signed [pipt_pkg::ABS_W-1:0]   abs_x;
    logic signed [pipt_pkg::ABS_W-1:0]   abs_y;
    logic signed [pipt_pkg::DIFF_W-1:0]  a_w;
    logic signed [pipt_pkg::DIFF_W-1:0]  b_w;
    logic signed [pipt_pkg::DIFF_W-1:0]  c_w;
    logic signed [pipt_pkg::DIFF_W-1:0]  d_w;
    logic                                straddle;
    logic                                advance;
    logic                                left;

    state_t                         adv_state;
    logic [pipt_pkg::CNT_W-1:0]     adv_idx;
    logic                           adv_closing;

    pipt_pkg::mac_op_t                   mac_op;
    logic signed [pipt_pkg::DIFF_W-1:0]  mac_mcand;
    logic signed [pipt_pkg::MPL_W-1:0]   mac_mplier;
    logic signed [pipt_pkg::ACC_W-1:0]   mac_acc;

    // Clamp the vertex count to the table size
    assign n_eff = (32'(vertex_count) > 32'(pipt_pkg::MAX_VERTICES))
                 ? pipt_pkg::CNT_W'(pipt_pkg::MAX_VERTICES)
                 : pipt_pkg::CNT_W'(vertex_count);

    // Absolute vertex from the table word
    assign abs_x = pipt_pkg::ABS_W'(center_x) + pipt_pkg::ABS_W'(rd_data.ox);
    assign abs_y = pipt_pkg::ABS_W'(center_y) + pipt_pkg::ABS_W'(rd_data.oy);

    // Edge from prev (i) to cur (j): row test and cross-multiply operands
    assign straddle = (prev_y_reg > pipt_pkg::ABS_W'(ty_reg))
                   != (cur_y_reg > pipt_pkg::ABS_W'(ty_reg));
    assign a_w = pipt_pkg::DIFF_W'(tx_reg) - pipt_pkg::DIFF_W'(prev_x_reg);
    assign b_w = pipt_pkg::DIFF_W'(cur_y_reg) - pipt_pkg::DIFF_W'(prev_y_reg);
    assign c_w = pipt_pkg::DIFF_W'(cur_x_reg) - pipt_pkg::DIFF_W'(prev_x_reg);
    assign d_w = pipt_pkg::DIFF_W'(ty_reg) - pipt_pkg::DIFF_W'(prev_y_reg);

    // Point is left of the edge when a*b - c*d has the sign opposite to dy
    assign left = dypos_reg ? mac_acc[pipt_pkg::ACC_W-1]
                            : (!mac_acc[pipt_pkg::ACC_W-1] && (mac_acc != '0));

    assign advance = ((state_reg == S_EDGE) && !straddle) || (state_reg == S_DECIDE);

    // Step to the next edge, the closing edge, or the end
    always_comb
    begin
        adv_idx     = idx_reg;
        adv_closing = closing_reg;
        priority if (closing_reg)
        begin
            adv_state = S_FINISH;
        end
        else if (idx_reg == n_reg - pipt_pkg::CNT_W'(1))
        begin
            adv_state   = S_CLOSE;
            adv_closing = 1'b1;
        end
        else
        begin
            adv_state = S_FETCH;
            adv_idx   = idx_reg + pipt_pkg::CNT_W'(1);
        end
    end

    // Sequencer next state and shared-unit commands
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        step_next    = step_reg;
        poly_next    = poly_reg;
        closing_next = closing_reg;
        mac_op       = '0;
        mac_mcand    = a_reg;
        mac_mplier   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next       = n_eff;
                    idx_next     = '0;
                    poly_next    = 1'b0;
                    closing_next = 1'b0;
                    state_next   = (n_eff < pipt_pkg::CNT_W'(3)) ? S_FINISH : S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (idx_reg == '0)
                begin
                    idx_next   = pipt_pkg::CNT_W'(1);
                    state_next = S_FETCH;
                end
                else
                begin
                    state_next = S_EDGE;
                end
            end
            S_CLOSE:
            begin
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                if (straddle)
                begin
                    step_next  = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next   = adv_state;
                    idx_next     = adv_idx;
                    closing_next = adv_closing;
                end
            end
            S_MUL:
            begin
                mac_op.issue = 1'b1;
                unique case (step_reg)
                    2'd0:
                    begin
                        mac_op.clear = 1'b1;
                        mac_mcand    = a_reg;
                        mac_mplier   = pipt_pkg::MPL_W'({1'b0, b_reg[pipt_pkg::PART_W-1:0]});
                    end
                    2'd1:
                    begin
                        mac_op.shift = 1'b1;
                        mac_mcand    = a_reg;
                        mac_mplier   = pipt_pkg::MPL_W'(
                                       $signed(b_reg[pipt_pkg::DIFF_W-1:pipt_pkg::PART_W]));
                    end
                    2'd2:
                    begin
                        mac_op.sub   = 1'b1;
                        mac_mcand    = c_reg;
                        mac_mplier   = pipt_pkg::MPL_W'({1'b0, d_reg[pipt_pkg::PART_W-1:0]});
                    end
                    2'd3:
                    begin
                        mac_op.sub   = 1'b1;
                        mac_op.shift = 1'b1;
                        mac_mcand    = c_reg;
                        mac_mplier   = pipt_pkg::MPL_W'(
                                       $signed(d_reg[pipt_pkg::DIFF_W-1:pipt_pkg::PART_W]));
                    end
                    default:
                    begin
                        mac_op = '0;
                    end
                endcase
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (left)
                begin
                    poly_next = !poly_reg;
                end
                state_next   = adv_state;
                idx_next     = adv_idx;
                closing_next = adv_closing;
            end
            S_FINISH:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold sequencer state and result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            n_reg       <= '0;
            step_reg    <= '0;
            poly_reg    <= 1'b0;
            closing_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            n_reg       <= n_next;
            step_reg    <= step_next;
            poly_reg    <= poly_next;
            closing_reg <= closing_next;
        end
    end

    // Point, vertex and operand registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            tx_reg <= point_x;
            ty_reg <= point_y;
        end
        if (state_reg == S_LOAD)
        begin
            if (idx_reg == '0)
            begin
                prev_x_reg  <= abs_x;
                prev_y_reg  <= abs_y;
                first_x_reg <= abs_x;
                first_y_reg <= abs_y;
            end
            else
            begin
                cur_x_reg <= abs_x;
                cur_y_reg <= abs_y;
            end
        end
        if (state_reg == S_CLOSE)
        begin
            cur_x_reg <= first_x_reg;
            cur_y_reg <= first_y_reg;
        end
        if (state_reg == S_EDGE)
        begin
            a_reg     <= a_w;
            b_reg     <= b_w;
            c_reg     <= c_w;
            d_reg     <= d_w;
            dypos_reg <= !b_w[pipt_pkg::DIFF_W-1];
        end
        if (advance)
        begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
    end

    pipt_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (mac_op),
        .mcand  (mac_mcand),
        .mplier (mac_mplier),
        .acc    (mac_acc)
    );

    assign rd_addr   = idx_reg[pipt_pkg::ADDR_W-1:0];
    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_FINISH);
    assign stat.poly = poly_reg;

    // Table reads stay within the vertices in use
    ap_fetch_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FETCH |-> idx_reg < n_reg)
        else $error("vertex fetch beyond vertex count");

    // Fewer than three vertices never report inside
    ap_few_vertices: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) && (n_reg < pipt_pkg::CNT_W'(3)) |-> !poly_reg)
        else $error("degenerate polygon reported inside");

    // The crossing decision reads a fully drained accumulator
    ap_decide_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DECIDE |-> $past(state_reg, 2) == S_MUL)
        else $error("crossing decided before products drained");

endmodule

// ===== hdl/point_in_polygon_prism_test_top.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_prism_test_top
// Tests points against a polygonal prism: even-odd crossing test over a
// vertex table plus a height band check around center z.
//
// Usage:
//   cfg channel: cfg_index selects vertex_count, center_x, center_y,
//   center_z or half_height; always ready. Write only while idle.
//   req channel: a load request writes one vertex offset and
//   gives no result. A test request gives one result on the res channel.
//   A test reads the n vertices in use one by one and, for every edge that
//   spans the point's y, runs the four partial products through the shared
//   multiplier, then drains; when fewer than three vertices are in use the
//   sequencer goes straight to its finish state. A new request is taken in
//   the cycle after a result is loaded; loads are taken every cycle while
//   no test is in work.
//   One request is in work at a time; req_ready is low during a test. The
//   result sits in an output register, so the next request is taken as
//   soon as the result is handed over, even if res_ready stays low; a
//   second finished result waits in the sequencer until the register frees.
//   Reset clears the configuration registers to zero and the block comes up idle; vertex
//   table entries must be loaded before they are used.
// ----------------------------------------------------------------------------
module point_in_polygon_prism_test_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pipt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pipt_pkg::COORD_W-1:0]      cfg_data,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  pipt_pkg::req_t                    req_data,
    output logic                              res_valid,
    input  logic                              res_ready,
    output pipt_pkg::res_t                    res_data
);

    logic [pipt_pkg::VCNT_W-1:0]          vertex_count_reg;
    logic signed [pipt_pkg::COORD_W-1:0]  center_x_reg;
    logic signed [pipt_pkg::COORD_W-1:0]  center_y_reg;
    logic signed [pipt_pkg::COORD_W-1:0]  center_z_reg;
    logic [pipt_pkg::HH_W-1:0]            half_height_reg;

    logic signed [pipt_pkg::COORD_W-1:0]  pz_reg;
    logic                                 res_valid_reg;
    pipt_pkg::res_t                       res_data_reg;

    logic                                 req_take;
    logic                                 test_take;
    logic                                 ram_we;
    logic [pipt_pkg::ADDR_W-1:0]          widx;
    logic [pipt_pkg::ADDR_W-1:0]          rd_addr;
    logic [2*pipt_pkg::COORD_W-1:0]       rd_word;
    pipt_pkg::vert_t                      wr_vert;
    pipt_pkg::seq_stat_t                  stat;
    logic                                 res_free;
    logic                                 res_load;

    logic signed [pipt_pkg::BAND_W-1:0]   band_lo;
    logic signed [pipt_pkg::BAND_W-1:0]   band_hi;
    logic signed [pipt_pkg::BAND_W-1:0]   pz_wide;
    logic                                 in_band;

    assign cfg_ready = 1'b1;
    assign req_ready = stat.idle;
    assign req_take  = req_valid && req_ready;
    assign test_take = req_take && (req_data.req_type == pipt_pkg::REQ_TEST);

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            center_z_reg     <= '0;
            half_height_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (pipt_pkg::cfg_reg_t'(cfg_index))
                pipt_pkg::REG_VERTEX_COUNT: vertex_count_reg <= cfg_data[pipt_pkg::VCNT_W-1:0];
                pipt_pkg::REG_CENTER_X:     center_x_reg     <= cfg_data;
                pipt_pkg::REG_CENTER_Y:     center_y_reg     <= cfg_data;
                pipt_pkg::REG_CENTER_Z:     center_z_reg     <= cfg_data;
                pipt_pkg::REG_HALF_HEIGHT:  half_height_reg  <= cfg_data[pipt_pkg::HH_W-1:0];
                default:                    vertex_count_reg <= vertex_count_reg;
            endcase
        end
    end

    // Vertex table: drop loads to slots past the table
    assign widx    = pipt_pkg::ADDR_W'(req_data.vertex_index);
    assign ram_we  = req_take && (req_data.req_type == pipt_pkg::REQ_LOAD)
                  && (32'(req_data.vertex_index) < 32'(pipt_pkg::MAX_VERTICES));
    assign wr_vert.ox = req_data.pos_x;
    assign wr_vert.oy = req_data.pos_y;

    pipt_ram #(
        .WIDTH (2 * pipt_pkg::COORD_W),
        .DEPTH (pipt_pkg::MAX_VERTICES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx),
        .wdata (wr_vert),
        .raddr (rd_addr),
        .rdata (rd_word)
    );

    pipt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (test_take),
        .point_x      (req_data.pos_x),
        .point_y      (req_data.pos_y),
        .vertex_count (vertex_count_reg),
        .center_x     (center_x_reg),
        .center_y     (center_y_reg),
        .res_free     (res_free),
        .rd_addr      (rd_addr),
        .rd_data      (pipt_pkg::vert_t'(rd_word)),
        .stat         (stat)
    );

    // Hold the test point z for the band check
    always_ff @(posedge clk)
    begin
        if (test_take)
        begin
            pz_reg <= req_data.pos_z;
        end
    end

    // Height band, bounds included
    assign band_lo = pipt_pkg::BAND_W'(center_z_reg)
                   - $signed(pipt_pkg::BAND_W'(half_height_reg));
    assign band_hi = pipt_pkg::BAND_W'(center_z_reg)
                   + $signed(pipt_pkg::BAND_W'(half_height_reg));
    assign pz_wide = pipt_pkg::BAND_W'(pz_reg);
    assign in_band = (pz_wide >= band_lo) && (pz_wide <= band_hi);

    // Output register: load a finished result when the slot is free
    assign res_free = !res_valid_reg || res_ready;
    assign res_load = stat.done && res_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_data_reg.inside_res <= stat.poly && in_band;
            res_data_reg.in_polygon <= stat.poly;
            res_data_reg.in_band    <= in_band;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // A test request makes the block busy on the next cycle
    ap_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
        test_take |=> !req_ready)
        else $error("test request did not start the sequencer");

    // A taken result is not followed by a result that was never produced
    ap_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !stat.done |=> !res_valid)
        else $error("result presented without a finished test");

endmodule

// ===== tb/point_in_polygon_prism_test_top_test.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_prism_test_top_test
// Drives vertex loads and point tests into the prism tester, keeps a
// shadow of the vertex table and registers, predicts every verdict with an
// exact wide-integer crossing test and band check, and compares each
// result in order. Directed corner cases come first, then random star
// shaped polygons under random sender gaps and receiver stalls, then a long receiver hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module point_in_polygon_prism_test_top_test;

    import pipt_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 160;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_ITEMS  = 500;
    localparam int PHASE_TESTS   = 24;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic [HH_W-1:0]           HH_MAX    = 30'h3FFF_FFFF;
    localparam logic [CFG_IDX_W-1:0]      REG_UNMAPPED = 3'd7;

    typedef enum int {
        RX_ALWAYS,
        RX_HALF,
        RX_QUARTER,
        RX_MOSTLY
    } rx_mode_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_VERTEX_COUNT;
    logic [COORD_W-1:0]     cfg_data  = '0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    req_t                   req_data  = '0;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    res_t                   res_data;

    // Shadow of the block's registers and vertex table
    logic [VCNT_W-1:0]          shadow_count = '0;
    logic signed [COORD_W-1:0]  shadow_cx    = '0;
    logic signed [COORD_W-1:0]  shadow_cy    = '0;
    logic signed [COORD_W-1:0]  shadow_cz    = '0;
    logic [HH_W-1:0]            shadow_hh    = '0;
    logic signed [COORD_W-1:0]  shadow_vx [MAX_VERTICES];
    logic signed [COORD_W-1:0]  shadow_vy [MAX_VERTICES];

    res_t   pending_verdicts [$];
    int     error_count   = 0;
    int     cycle_count   = 0;
    int     burst_left    = 0;
    int     hold_requests = 0;
    int     hold_served   = 0;
    int     hold_left     = 0;
    int     rx_left       = 0;
    int     rx_tick       = 0;
    rx_mode_t rx_mode     = RX_ALWAYS;

    point_in_polygon_prism_test_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    always #2 clk = ~clk;

    // Even-odd crossing parity, exact at 72 bits
    function automatic logic crossing_parity(input logic signed [COORD_W-1:0] tx,
                                             input logic signed [COORD_W-1:0] ty);
        int n;
        int i;
        int j;
        logic odd;
        logic left;
        logic signed [71:0] px, py, xi, yi, xj, yj, dy;
        n = (shadow_count > MAX_VERTICES) ? MAX_VERTICES : int'(shadow_count);
        odd = 1'b0;
        if (n < 3)
            return 1'b0;
        px = tx;
        py = ty;
        for (i = 0; i < n; i++)
        begin
            j  = (i + 1 == n) ? 0 : i + 1;
            xi = shadow_cx + shadow_vx[i];
            yi = shadow_cy + shadow_vy[i];
            xj = shadow_cx + shadow_vx[j];
            yj = shadow_cy + shadow_vy[j];
            if ((yi > py) != (yj > py))
            begin
                dy = yj - yi;
                if (dy > 0)
                    left = (px - xi) * dy < (xj - xi) * (py - yi);
                else
                    left = (xj - xi) * (py - yi) < (px - xi) * dy;
                if (left)
                    odd = ~odd;
            end
        end
        return odd;
    endfunction

    // Verdict for one test request under the current shadow state
    function automatic res_t judge_point(input logic signed [COORD_W-1:0] tx,
                                         input logic signed [COORD_W-1:0] ty,
                                         input logic signed [COORD_W-1:0] tz);
        res_t v;
        logic signed [71:0] z, lo, hi, hh;
        z  = tz;
        hh = {42'd0, shadow_hh};
        lo = shadow_cz;
        hi = shadow_cz;
        lo = lo - hh;
        hi = hi + hh;
        v.in_polygon = crossing_parity(tx, ty);
        v.in_band    = (z >= lo) && (z <= hi);
        v.inside_res = v.in_polygon & v.in_band;
        return v;
    endfunction

    // Random offset around a base, truncated to a coordinate
    function automatic logic [COORD_W-1:0] near(input longint base, input longint spread);
        logic [63:0] u;
        longint off;
        u   = {$urandom, $urandom};
        off = longint'(u % (2 * spread + 1)) - spread;
        return 32'(base + off);
    endfunction

    function automatic logic [COORD_W-1:0] pick_center();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return COORD_MAX;
            3:       return COORD_MIN;
            default: return near(0, 1 << 20);
        endcase
    endfunction

    // Track register writes and requests as the block takes them
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_VERTEX_COUNT: shadow_count = cfg_data[VCNT_W-1:0];
                REG_CENTER_X:     shadow_cx    = cfg_data;
                REG_CENTER_Y:     shadow_cy    = cfg_data;
                REG_CENTER_Z:     shadow_cz    = cfg_data;
                REG_HALF_HEIGHT:  shadow_hh    = cfg_data[HH_W-1:0];
                default:          ;
            endcase
        end
        if (rst_n && req_valid && req_ready)
        begin
            if (req_data.req_type == REQ_LOAD)
            begin
                shadow_vx[req_data.vertex_index] = req_data.pos_x;
                shadow_vy[req_data.vertex_index] = req_data.pos_y;
            end
            else
                pending_verdicts = {pending_verdicts,
                                    judge_point(req_data.pos_x, req_data.pos_y,
                                                req_data.pos_z)};
        end
    end

    // Compare each delivered verdict with the oldest prediction
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("verdict %b with no test pending", res_data);
                error_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (res_data.inside_res !== want.inside_res)
                begin
                    $error("inside_res: expected %0b, got %0b", want.inside_res,
                           res_data.inside_res);
                    error_count++;
                end
                if (res_data.in_polygon !== want.in_polygon)
                begin
                    $error("in_polygon: expected %0b, got %0b", want.in_polygon,
                           res_data.in_polygon);
                    error_count++;
                end
                if (res_data.in_band !== want.in_band)
                begin
                    $error("in_band: expected %0b, got %0b", want.in_band, res_data.in_band);
                    error_count++;
                end
            end
        end
    end

    // Receiver: switch stall patterns, honor long holds
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_tick++;
        if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS:  res_ready <= 1'b1;
                RX_HALF:    res_ready <= 1'($urandom_range(0, 1));
                RX_QUARTER: res_ready <= (rx_tick % 4 == 0);
                default:    res_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("point_in_polygon_prism_test_top_test: done, errors");
            $finish;
        end
    end

    // Offer one request, in bursts with random gaps between them
    task automatic send_req(input req_t r);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                burst_left = 40;
                gap        = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 12);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= r;
        burst_left--;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic send_load(input logic [VIDX_W-1:0] slot, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y);
        req_t r;
        r.req_type     = REQ_LOAD;
        r.vertex_index = slot;
        r.pos_x        = x;
        r.pos_y        = y;
        r.pos_z        = $urandom;
        send_req(r);
    endtask

    task automatic send_test(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z);
        req_t r;
        r.req_type     = REQ_TEST;
        r.vertex_index = VIDX_W'($urandom);
        r.pos_x        = x;
        r.pos_y        = y;
        r.pos_z        = z;
        send_req(r);
    endtask

    // Drop valid, wait for every verdict, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        req_valid  <= 1'b0;
        burst_left = 0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Program all five registers, with junk above the narrow fields
    task automatic set_prism(input int n, input logic [COORD_W-1:0] cx,
                             input logic [COORD_W-1:0] cy, input logic [COORD_W-1:0] cz,
                             input logic [HH_W-1:0] hh);
        logic [COORD_W-1:0] junk;
        junk = $urandom;
        write_reg(REG_VERTEX_COUNT, {junk[COORD_W-1:VCNT_W], VCNT_W'(n)});
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        junk = $urandom;
        write_reg(REG_HALF_HEIGHT, {junk[COORD_W-1:HH_W], hh});
    endtask

    task automatic test_directed();
        // nothing configured yet: too few vertices, zero-height band at zero
        send_test(0, 0, 0);
        send_load(0, -2560, -2560);
        send_load(1, 2560, -2560);
        send_load(2, 2560, 2560);
        send_load(3, -2560, 2560);
        wait_idle();
        set_prism(4, 1000, -1000, 0, 256);
        send_test(1000, -1000, 0);
        send_test(1000, -1000, 256);
        send_test(1000, -1000, 257);
        send_test(1000, -1000, -256);
        send_test(1000, -1000, -257);
        // points on the left and right edges, on a vertex row, on a corner
        send_test(1000 - 2560, -1000, 0);
        send_test(1000 + 2560, -1000, 0);
        send_test(1000, -1000 - 2560, 0);
        send_test(1000 - 2560, -1000 - 2560, 0);
        send_test(COORD_MAX, COORD_MIN, COORD_MAX);
        // full-scale offsets around a full-scale center: sums exceed 32 bits
        send_load(0, COORD_MAX, COORD_MAX);
        send_load(1, COORD_MIN, COORD_MAX);
        send_load(2, COORD_MIN, COORD_MIN);
        send_load(3, COORD_MAX, COORD_MIN);
        send_load(15, COORD_MIN, COORD_MAX);
        wait_idle();
        set_prism(4, COORD_MAX, COORD_MIN, COORD_MIN, HH_MAX);
        send_test(COORD_MAX, COORD_MIN, COORD_MIN);
        send_test(COORD_MIN, COORD_MAX, COORD_MAX);
        wait_idle();
        write_reg(REG_VERTEX_COUNT, 2);
        write_reg(REG_UNMAPPED, $urandom);
        send_test(COORD_MAX, COORD_MIN, COORD_MIN);
        wait_idle();
    endtask

    // Random star-shaped polygons, mostly probed near their outline
    task automatic test_random_shapes();
        int sent;
        int phase;
        int n;
        int sides;
        int k;
        int t;
        int kn;
        longint radius;
        longint lo_z;
        longint hi_z;
        real ang;
        real rr;
        int shape_x [MAX_VERTICES];
        int shape_y [MAX_VERTICES];
        logic signed [COORD_W-1:0] cx, cy, cz;
        logic [HH_W-1:0] hh;
        logic [COORD_W-1:0] px, py, pz;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase == 0)
                n = 16;
            else if (phase == 1)
                n = 31;
            else if (phase == 2)
                n = 3;
            else
            begin
                case ($urandom_range(0, 9))
                    0:       n = $urandom_range(0, 2);
                    1:       n = $urandom_range(17, 31);
                    default: n = $urandom_range(3, 16);
                endcase
            end
            sides = (n > MAX_VERTICES) ? MAX_VERTICES : ((n < 3) ? 4 : n);
            if ($urandom_range(0, 3) == 0)
                radius = longint'(1) << $urandom_range(21, 29);
            else
                radius = longint'(1) << $urandom_range(8, 20);
            cx = pick_center();
            cy = pick_center();
            cz = pick_center();
            case ($urandom_range(0, 5))
                0:       hh = '0;
                1:       hh = HH_MAX;
                2, 3:    hh = HH_W'($urandom);
                default: hh = HH_W'($urandom_range(0, 1 << 16));
            endcase
            lo_z = longint'(cz) - longint'(hh);
            hi_z = longint'(cz) + longint'(hh);

            // fill the whole table so any count can be evaluated
            for (k = 0; k < MAX_VERTICES; k++)
            begin
                if (k < sides)
                begin
                    ang = 6.283185307 * k / sides;
                    rr  = radius * (0.5 + 0.5 * $urandom_range(0, 1000) / 1000.0);
                    shape_x[k] = $rtoi(rr * $cos(ang));
                    shape_y[k] = $rtoi(rr * $sin(ang));
                end
                else
                begin
                    shape_x[k] = $urandom;
                    shape_y[k] = $urandom;
                end
                send_load(VIDX_W'(k), shape_x[k], shape_y[k]);
                sent++;
            end
            wait_idle();
            set_prism(n, cx, cy, cz, hh);

            for (t = 0; t < PHASE_TESTS; t++)
            begin
                k  = $urandom_range(0, sides - 1);
                kn = (k + 1 == sides) ? 0 : k + 1;
                case ($urandom_range(0, 5))
                    0:       pz = 32'(lo_z);
                    1:       pz = 32'(hi_z);
                    2:       pz = 32'(lo_z - 1);
                    3:       pz = 32'(hi_z + 1);
                    4:       pz = $urandom;
                    default: pz = near(longint'(cz), longint'(hh));
                endcase
                case ($urandom_range(0, 19))
                    0, 1:
                    begin
                        px = 32'(longint'(cx) + shape_x[k]);
                        py = 32'(longint'(cy) + shape_y[k]);
                    end
                    2, 3:
                    begin
                        px = near(longint'(cx), radius + radius / 2);
                        py = 32'(longint'(cy) + shape_y[k]);
                    end
                    4:
                    begin
                        px = 32'(longint'(cx) + (longint'(shape_x[k]) + shape_x[kn]) / 2);
                        py = 32'(longint'(cy) + (longint'(shape_y[k]) + shape_y[kn]) / 2);
                    end
                    5, 6:
                    begin
                        px = $urandom;
                        py = $urandom;
                    end
                    default:
                    begin
                        px = near(longint'(cx), radius + radius / 2);
                        py = near(longint'(cy), radius + radius / 2);
                    end
                endcase
                // now and then disturb a slot between tests
                if ($urandom_range(0, 9) == 0)
                    send_load(VIDX_W'($urandom), $urandom, $urandom);
                else
                    send_test(px, py, pz);
                sent++;
            end
            phase++;
        end
        wait_idle();
    endtask

    // Hold the receiver off while tests pile up, then pause the sender
    task automatic test_stall_and_pause();
        int t;
        hold_requests++;
        for (t = 0; t < 12; t++)
            send_test(near(longint'(shadow_cx), 1 << 12), near(longint'(shadow_cy), 1 << 12),
                      shadow_cz);
        @(negedge clk);
        req_valid  <= 1'b0;
        burst_left = 0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        for (t = 0; t < 6; t++)
            send_test($urandom, $urandom, $urandom);
        wait_idle();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_shapes();
        test_stall_and_pause();
        wait_idle();
        if (error_count == 0)
            $display("point_in_polygon_prism_test_top_test: done, clean");
        else
            $display("point_in_polygon_prism_test_top_test: done, errors");
        $finish;
    end

endmodule
